>>> rtl/vpbs_pkg.sv
// Package: shared types and constants of the picture boundary splitter.
package vpbs_pkg;

    // Look-ahead window: bytes held between transfers
    localparam int WinDepth = 8;

    typedef logic [WinDepth-1:0][7:0] window_t;

    // codec_mode register codes
    localparam logic [1:0] MODE_H264 = 2'd0;
    localparam logic [1:0] MODE_H265 = 2'd1;
    localparam logic [1:0] MODE_JPEG = 2'd2;
    localparam logic [1:0] MODE_PASS = 2'd3;

    // Register indexes
    localparam logic REG_CODEC_MODE = 1'b0;

    // Followers a check needs behind the byte being checked
    localparam logic [3:0] H264_LOOKAHEAD = 4'd8;
    localparam logic [3:0] HEVC_LOOKAHEAD = 4'd6;
    localparam logic [3:0] MARKER_LOOKAHEAD = 4'd1;
    localparam logic [3:0] APP_LOOKAHEAD = 4'd3;

    // H.264 NAL unit types
    localparam logic [4:0] H264_NAL_SLICE = 5'd1;
    localparam logic [4:0] H264_NAL_IDR = 5'd5;
    localparam logic [4:0] H264_NAL_SEI = 5'd6;
    localparam logic [4:0] H264_NAL_SPS = 5'd7;
    localparam logic [4:0] H264_NAL_PPS = 5'd8;
    localparam logic [4:0] H264_NAL_SUBSET_SPS = 5'd15;
    localparam logic [4:0] H264_NAL_SLICE_EXT = 5'd20;

    // H.265 NAL unit types
    localparam logic [5:0] HEVC_NAL_VCL_MAX = 6'd21;
    localparam logic [5:0] HEVC_NAL_VPS = 6'd32;
    localparam logic [5:0] HEVC_NAL_SPS = 6'd33;
    localparam logic [5:0] HEVC_NAL_PPS = 6'd34;
    localparam logic [5:0] HEVC_NAL_PREFIX_SEI = 6'd39;
    localparam logic [5:0] HEVC_NAL_SUFFIX_SEI = 6'd40;

    // JPEG markers
    localparam logic [7:0] JPEG_MARKER = 8'hFF;
    localparam logic [7:0] JPEG_SOI = 8'hD8;
    localparam logic [7:0] JPEG_EOI = 8'hD9;
    localparam logic [3:0] JPEG_APP_NIBBLE = 4'hE;

    typedef enum logic [1:0] {
        JPEG_SEEK_SOI,
        JPEG_APP_CHECK,
        JPEG_SEEK_EOI,
        JPEG_EOI_TAIL
    } jpeg_phase_t;

    // Per-stream parsing context
    typedef struct packed {
        logic        picture_seen;
        logic        stream_began;
        logic [16:0] skip_count;
        jpeg_phase_t jpeg_phase;
    } ctx_t;

    localparam ctx_t CTX_RESET = '{
        picture_seen: 1'b0,
        stream_began: 1'b0,
        skip_count:   17'd0,
        jpeg_phase:   JPEG_SEEK_SOI
    };

    // Verdict on the front byte of the window
    typedef struct packed {
        logic emit;
        logic unit_start;
    } verdict_t;

endpackage

>>> rtl/vpbs_in_if.sv
// Interface: input byte channel of the picture boundary splitter.
interface vpbs_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] in_byte;
    logic       end_of_stream;

    modport source (output valid, output in_byte, output end_of_stream, input ready);
    modport sink (input valid, input in_byte, input end_of_stream, output ready);
endinterface

>>> rtl/vpbs_out_if.sv
// Interface: output byte channel of the picture boundary splitter.
interface vpbs_out_if;
    logic       valid;
    logic       ready;
    logic [7:0] out_byte;
    logic       unit_start;
    logic       run_last;
    logic       stream_end;

    modport source (output valid, output out_byte, output unit_start, output run_last,
                    output stream_end, input ready);
    modport sink (input valid, input out_byte, input unit_start, input run_last,
                  input stream_end, output ready);
endinterface

>>> rtl/video_picture_boundary_splitter.sv
// Top level: picture boundary splitter for H.264, H.265 and JPEG byte streams.
//
// Usage:
//   in_stream  - one stream byte per transfer; end_of_stream marks the final byte.
//   out_stream - bytes leaving an 8-byte look-ahead window, unit_start on the
//                first byte of each picture unit, run_last on the last byte caused by an
//                input transfer, stream_end on the last byte of a flushed stream.
//   APB port   - codec_mode at byte address 0 (0 H.264, 1 H.265, 2 JPEG,
//                3 pass-through). Write it only while the block is idle.
// Throughput: one input transfer per cycle while no flush runs and no result
//   waits. A byte leaves the window once eight later bytes sit behind it; its
//   result is registered and shows in the cycle after the transfer that pushed it out.
// End of stream: the window drains one byte per cycle while no result waits, then
//   a closing step follows, with in_stream.ready low. The last result is held back
//   one slot so run_last/stream_end can be set on it even when JPEG drops the
//   bytes that follow; the parsing context then returns to its reset state.
// Stall: while a result waits with out_stream.ready low, the whole block holds;
//   a waiting result is overwritten only in the cycle it is taken.
// Reset: rst_n clears the window fill, context, flush and valid flags and the
//   mode register; window bytes are not cleared.
module video_picture_boundary_splitter (
    input  logic                clk,
    input  logic                rst_n,
    vpbs_in_if.sink             in_stream,
    vpbs_out_if.source          out_stream,
    input  logic                psel,
    input  logic                penable,
    input  logic                pwrite,
    input  logic [2:0]          paddr,
    input  logic [31:0]         pwdata,
    output logic [31:0]         prdata,
    output logic                pready
);

    localparam logic [3:0] FILL_FULL = 4'(vpbs_pkg::WinDepth);

    // Configuration
    logic [1:0] mode_reg;
    logic       cfg_write;

    // Window and context
    vpbs_pkg::window_t win_reg, win_next;
    logic [3:0]        fill_reg, fill_next;
    vpbs_pkg::ctx_t    ctx_reg, ctx_next;
    logic              flush_reg, flush_next;

    // Held result during a flush
    logic       hold_valid_reg, hold_valid_next;
    logic [7:0] hold_byte_reg, hold_byte_next;
    logic       hold_unit_reg, hold_unit_next;

    // Output register
    logic       out_valid_reg, out_valid_next;
    logic [7:0] out_byte_reg, out_byte_next;
    logic       out_unit_reg, out_unit_next;
    logic       out_last_reg, out_last_next;
    logic       out_end_reg, out_end_next;

    // Handshake and evaluation
    logic               out_free;
    logic               in_ready;
    logic               in_fire;
    logic               flush_step;
    logic [3:0]         avail;
    vpbs_pkg::ctx_t     eval_ctx;
    vpbs_pkg::verdict_t verdict;

    assign cfg_write = psel && penable && pwrite;
    assign pready    = 1'b1;
    assign prdata    = (paddr[2] == vpbs_pkg::REG_CODEC_MODE) ? {30'd0, mode_reg} : 32'd0;

    assign out_free   = !out_valid_reg || out_stream.ready;
    assign in_ready   = !flush_reg && out_free;
    assign in_fire    = in_stream.valid && in_ready;
    assign flush_step = flush_reg && out_free;

    // Normal transfers check with a full window; a drain has fill-1 followers
    assign avail = flush_reg ? (fill_reg - 4'd1) : FILL_FULL;

    vpbs_front_eval u_eval (
        .codec_mode (mode_reg),
        .win        (win_reg),
        .avail      (avail),
        .ctx_cur    (ctx_reg),
        .ctx_next   (eval_ctx),
        .verdict    (verdict)
    );

    always_comb
    begin
        win_next        = win_reg;
        fill_next       = fill_reg;
        ctx_next        = ctx_reg;
        flush_next      = flush_reg;
        hold_valid_next = hold_valid_reg;
        hold_byte_next  = hold_byte_reg;
        hold_unit_next  = hold_unit_reg;
        out_valid_next  = out_valid_reg && !out_stream.ready;
        out_byte_next   = out_byte_reg;
        out_unit_next   = out_unit_reg;
        out_last_next   = out_last_reg;
        out_end_next    = out_end_reg;

        if (in_fire)
        begin
            if (fill_reg == FILL_FULL)
            begin
                // Front byte leaves, new byte enters at the back
                for (int i = 0; i < vpbs_pkg::WinDepth - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                win_next[vpbs_pkg::WinDepth - 1] = in_stream.in_byte;
                ctx_next = eval_ctx;
                if (verdict.emit)
                begin
                    if (in_stream.end_of_stream)
                    begin
                        hold_valid_next = 1'b1;
                        hold_byte_next  = win_reg[0];
                        hold_unit_next  = verdict.unit_start;
                    end
                    else
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = win_reg[0];
                        out_unit_next  = verdict.unit_start;
                        out_last_next  = 1'b1;
                        out_end_next   = 1'b0;
                    end
                end
            end
            else
            begin
                win_next[fill_reg[2:0]] = in_stream.in_byte;
                fill_next = fill_reg + 4'd1;
            end
            if (in_stream.end_of_stream)
            begin
                flush_next = 1'b1;
            end
        end

        if (flush_step)
        begin
            if (fill_reg != 4'd0)
            begin
                for (int i = 0; i < vpbs_pkg::WinDepth - 1; i++)
                begin
                    win_next[i] = win_reg[i + 1];
                end
                fill_next = fill_reg - 4'd1;
                ctx_next  = eval_ctx;
                if (verdict.emit)
                begin
                    // A newer result proves the held one is not the last
                    if (hold_valid_reg)
                    begin
                        out_valid_next = 1'b1;
                        out_byte_next  = hold_byte_reg;
                        out_unit_next  = hold_unit_reg;
                        out_last_next  = 1'b0;
                        out_end_next   = 1'b0;
                    end
                    hold_valid_next = 1'b1;
                    hold_byte_next  = win_reg[0];
                    hold_unit_next  = verdict.unit_start;
                end
            end
            else
            begin
                // Closing cycle: release the held result as the final one
                if (hold_valid_reg)
                begin
                    out_valid_next = 1'b1;
                    out_byte_next  = hold_byte_reg;
                    out_unit_next  = hold_unit_reg;
                    out_last_next  = 1'b1;
                    out_end_next   = 1'b1;
                end
                hold_valid_next = 1'b0;
                ctx_next        = vpbs_pkg::CTX_RESET;
                flush_next      = 1'b0;
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            mode_reg       <= vpbs_pkg::MODE_H264;
            fill_reg       <= 4'd0;
            ctx_reg        <= vpbs_pkg::CTX_RESET;
            flush_reg      <= 1'b0;
            hold_valid_reg <= 1'b0;
            out_valid_reg  <= 1'b0;
        end
        else
        begin
            if (cfg_write && (paddr[2] == vpbs_pkg::REG_CODEC_MODE))
            begin
                mode_reg <= pwdata[1:0];
            end
            fill_reg       <= fill_next;
            ctx_reg        <= ctx_next;
            flush_reg      <= flush_next;
            hold_valid_reg <= hold_valid_next;
            out_valid_reg  <= out_valid_next;
        end
    end

    // Payload registers
    always_ff @(posedge clk)
    begin
        win_reg       <= win_next;
        hold_byte_reg <= hold_byte_next;
        hold_unit_reg <= hold_unit_next;
        out_byte_reg  <= out_byte_next;
        out_unit_reg  <= out_unit_next;
        out_last_reg  <= out_last_next;
        out_end_reg   <= out_end_next;
    end

    assign in_stream.ready       = in_ready;
    assign out_stream.valid      = out_valid_reg;
    assign out_stream.out_byte   = out_byte_reg;
    assign out_stream.unit_start = out_unit_reg;
    assign out_stream.run_last   = out_last_reg;
    assign out_stream.stream_end = out_end_reg;

endmodule

>>> rtl/vpbs_front_eval.sv
// Module: boundary check on the front byte of the look-ahead window.
module vpbs_front_eval (
    input  logic [1:0]       codec_mode,
    input  vpbs_pkg::window_t win,
    input  logic [3:0]       avail,
    input  vpbs_pkg::ctx_t   ctx_cur,
    output vpbs_pkg::ctx_t   ctx_next,
    output vpbs_pkg::verdict_t verdict
);

    logic       start_code;
    logic [4:0] avc_type;
    logic [5:0] hevc_type;
    logic       avc_first;
    logic       avc_bound;
    logic       hevc_first;
    logic       hevc_bound;
    logic       is_avc;
    logic [3:0] need;
    logic       first_slice;
    logic       boundary;
    logic       soi_hit;
    logic       eoi_hit;
    logic       app_hit;

    assign start_code = (win[0] == 8'h00) && (win[1] == 8'h00) && (win[2] == 8'h01);
    assign avc_type   = win[3][4:0];
    assign hevc_type  = win[3][6:1];

    assign avc_first = start_code &&
        ((((avc_type == vpbs_pkg::H264_NAL_IDR) || (avc_type == vpbs_pkg::H264_NAL_SLICE))
          && win[4][7]) ||
         ((avc_type == vpbs_pkg::H264_NAL_SLICE_EXT) && win[7][7]));
    assign avc_bound = avc_first || (start_code &&
        ((avc_type == vpbs_pkg::H264_NAL_SUBSET_SPS) || (avc_type == vpbs_pkg::H264_NAL_SPS) ||
         (avc_type == vpbs_pkg::H264_NAL_PPS) || (avc_type == vpbs_pkg::H264_NAL_SEI)));

    assign hevc_first = start_code && (hevc_type <= vpbs_pkg::HEVC_NAL_VCL_MAX) && win[5][7];
    assign hevc_bound = hevc_first || (start_code &&
        ((hevc_type == vpbs_pkg::HEVC_NAL_VPS) || (hevc_type == vpbs_pkg::HEVC_NAL_SPS) ||
         (hevc_type == vpbs_pkg::HEVC_NAL_PPS) ||
         (hevc_type == vpbs_pkg::HEVC_NAL_PREFIX_SEI) ||
         (hevc_type == vpbs_pkg::HEVC_NAL_SUFFIX_SEI)));

    assign is_avc      = (codec_mode == vpbs_pkg::MODE_H264);
    assign need        = is_avc ? vpbs_pkg::H264_LOOKAHEAD : vpbs_pkg::HEVC_LOOKAHEAD;
    assign first_slice = is_avc ? avc_first : hevc_first;
    assign boundary    = is_avc ? avc_bound : hevc_bound;

    assign soi_hit = (avail >= vpbs_pkg::MARKER_LOOKAHEAD) &&
                     (win[0] == vpbs_pkg::JPEG_MARKER) && (win[1] == vpbs_pkg::JPEG_SOI);
    assign eoi_hit = (avail >= vpbs_pkg::MARKER_LOOKAHEAD) &&
                     (win[0] == vpbs_pkg::JPEG_MARKER) && (win[1] == vpbs_pkg::JPEG_EOI);
    assign app_hit = (avail >= vpbs_pkg::APP_LOOKAHEAD) &&
                     (win[0] == vpbs_pkg::JPEG_MARKER) &&
                     (win[1][7:4] == vpbs_pkg::JPEG_APP_NIBBLE);

    always_comb
    begin
        logic seen;
        seen = ctx_cur.picture_seen;
        ctx_next = ctx_cur;
        ctx_next.stream_began = 1'b1;
        verdict.emit = 1'b1;
        verdict.unit_start = 1'b0;

        case (codec_mode) inside
            vpbs_pkg::MODE_H264, vpbs_pkg::MODE_H265:
            begin
                verdict.unit_start = !ctx_cur.stream_began;
                if (ctx_cur.skip_count != 17'd0)
                begin
                    ctx_next.skip_count = ctx_cur.skip_count - 17'd1;
                end
                else if (avail >= need)
                begin
                    if (seen && boundary)
                    begin
                        verdict.unit_start = 1'b1;
                        seen = 1'b0;
                    end
                    if (!seen && first_slice)
                    begin
                        seen = 1'b1;
                        ctx_next.skip_count = 17'(need - 4'd1);
                    end
                    ctx_next.picture_seen = seen;
                end
            end
            vpbs_pkg::MODE_JPEG:
            begin
                if (ctx_cur.jpeg_phase == vpbs_pkg::JPEG_SEEK_SOI)
                begin
                    // Bytes outside an image are dropped
                    verdict.emit = soi_hit;
                    verdict.unit_start = soi_hit;
                    if (soi_hit)
                    begin
                        ctx_next.jpeg_phase = vpbs_pkg::JPEG_APP_CHECK;
                        ctx_next.skip_count = 17'd1;
                    end
                end
                else if (ctx_cur.skip_count != 17'd0)
                begin
                    ctx_next.skip_count = ctx_cur.skip_count - 17'd1;
                end
                else
                begin
                    case (ctx_cur.jpeg_phase)
                        vpbs_pkg::JPEG_APP_CHECK:
                        begin
                            if (app_hit)
                            begin
                                // Segment length plus the marker's second byte
                                ctx_next.skip_count = {1'b0, win[2], win[3]} + 17'd1;
                            end
                            else if (eoi_hit)
                            begin
                                ctx_next.jpeg_phase = vpbs_pkg::JPEG_EOI_TAIL;
                            end
                            else
                            begin
                                ctx_next.jpeg_phase = vpbs_pkg::JPEG_SEEK_EOI;
                            end
                        end
                        vpbs_pkg::JPEG_SEEK_EOI:
                        begin
                            if (eoi_hit)
                            begin
                                ctx_next.jpeg_phase = vpbs_pkg::JPEG_EOI_TAIL;
                            end
                        end
                        default:
                        begin
                            ctx_next.jpeg_phase = vpbs_pkg::JPEG_SEEK_SOI;
                        end
                    endcase
                end
            end
            default:
            begin
                // Pass-through: no marks
                verdict.unit_start = 1'b0;
            end
        endcase
    end

endmodule
